>>> rtl/sac_pkg.sv
// Shared types and constants for the slot allocator.
// Holds the request and result words, their codes, and the count store ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

  localparam int SLOT_W  = 5;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_REF   = 2'd2,
    REQ_UNREF = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [INDEX_W-1:0] slot_index;
  } req_word_t;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  granted_slot;
    logic [COUNT_W-1:0] ref_count;
  } rsp_word_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } cnt_rd_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
    logic [COUNT_W-1:0] data;
  } cnt_wr_t;

endpackage

`default_nettype wire

>>> rtl/slot_allocator_with_refcounts_unit.sv
// Slot allocator with per-slot reference counts: top level.
// Depends on sac_pkg and sac_ref_store.
//
// Usage:
// Requests arrive as words on the in channel (valid/ready); each request gives
// exactly one result word on the out channel (valid/ready), in order.
// Alloc grants the lowest free slot, free releases a slot and clears its count,
// ref and unref step the count with saturation at both ends and report it.
// A request accepted into the s1 stage reads its count from the store's registered
// read port, and its result is registered in the output register that drives
// out_valid_o once that stage advances. One request is taken per cycle
// when the receiver keeps up; the count store's single read-modify-write path
// sets that rate, and a write to the same slot is forwarded to a read that
// overlaps it.
// While the output register holds an untaken result, the stage behind it
// keeps any request it holds and in_ready_o falls if it holds one, so nothing is lost or repeated.
// Reset marks the reserved slots used with a count of one and all other
// slots free with a count of zero; it takes effect at once, with no sweep.
`timescale 1ns / 1ps
`default_nettype none

module slot_allocator_with_refcounts_unit #(
  parameter int SLOTS          = 32,
  parameter int RESERVED_SLOTS = 3
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire sac_pkg::req_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output sac_pkg::rsp_word_t       out_word_o
);

  localparam logic [SLOTS-1:0] RSV_MASK = SLOTS'((64'd1 << RESERVED_SLOTS) - 64'd1);

  logic                        s1_vld_q;
  sac_pkg::req_word_t          s1_q;
  logic [SLOTS-1:0]            used_q;
  logic [SLOTS-1:0]            used_d;
  logic                        out_vld_q;
  sac_pkg::rsp_word_t          out_q;
  sac_pkg::rsp_word_t          rsp;
  logic                        out_free;
  logic                        adv;
  logic                        in_acc;
  sac_pkg::cnt_rd_t            rd;
  sac_pkg::cnt_wr_t            wr;
  logic [sac_pkg::COUNT_W-1:0] cur;
  logic [SLOTS-1:0]            open_slots;
  logic [sac_pkg::SLOT_W-1:0]  grant;
  logic                        in_range;
  logic [sac_pkg::SLOT_W-1:0]  idx;

  assign out_free   = !out_vld_q || out_ready_i;
  assign adv        = s1_vld_q && out_free;
  assign in_ready_o = !s1_vld_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  assign rd.en   = in_acc;
  assign rd.addr = in_word_i.slot_index[sac_pkg::SLOT_W-1:0];

  sac_ref_store #(
    .SLOTS          (SLOTS),
    .RESERVED_SLOTS (RESERVED_SLOTS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .wr_i      (wr),
    .rd_data_o (cur)
  );

  assign open_slots = ~used_q;
  assign idx        = s1_q.slot_index[sac_pkg::SLOT_W-1:0];
  assign in_range   = s1_q.slot_index < sac_pkg::INDEX_W'(SLOTS);

  always_comb begin
    grant = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (open_slots[i]) begin
        grant = sac_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rsp.status       = sac_pkg::ST_OK;
    rsp.granted_slot = '0;
    rsp.ref_count    = '0;
    wr.en            = 1'b0;
    wr.addr          = idx;
    wr.data          = '0;
    used_d           = used_q;
    if (s1_q.req_type == sac_pkg::REQ_ALLOC) begin
      if (|open_slots) begin
        rsp.granted_slot = grant;
        wr.en            = 1'b1;
        wr.addr          = grant;
        used_d[grant]    = 1'b1;
      end else begin
        rsp.status = sac_pkg::ST_FULL;
      end
    end else if (!in_range) begin
      rsp.status = sac_pkg::ST_RANGE;
    end else begin
      wr.en = 1'b1;
      case (s1_q.req_type)
        sac_pkg::REQ_FREE: begin
          used_d[idx] = 1'b0;
        end
        sac_pkg::REQ_REF: begin
          wr.data = (cur == sac_pkg::COUNT_MAX) ? cur : cur + 1'b1;
        end
        sac_pkg::REQ_UNREF: begin
          wr.data = (cur == '0) ? cur : cur - 1'b1;
        end
        default: begin
          wr.en = 1'b0;
        end
      endcase
      rsp.ref_count = wr.data;
    end
    wr.en = wr.en && adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      used_q    <= RSV_MASK;
    end else begin
      if (in_ready_o) begin
        s1_vld_q <= in_valid_i;
      end
      if (adv) begin
        used_q <= used_d;
      end
      if (out_free) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_word_i;
    end
    if (adv) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/sac_ref_store.sv
// Reference count store: one synchronous memory with a registered read port.
// Valid bits give the reset counts until an entry is written; write-first bypass.
// Depends on sac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sac_ref_store #(
  parameter int SLOTS          = 32,
  parameter int RESERVED_SLOTS = 3
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire sac_pkg::cnt_rd_t        rd_i,
  input  wire sac_pkg::cnt_wr_t        wr_i,
  output logic [sac_pkg::COUNT_W-1:0]  rd_data_o
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOTS-1:0] RSV_MASK = SLOTS'((64'd1 << RESERVED_SLOTS) - 64'd1);

  logic [sac_pkg::COUNT_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]            vld_q;
  logic [sac_pkg::COUNT_W-1:0] mem_rd_q;
  logic [sac_pkg::COUNT_W-1:0] byp_data_q;
  logic                        byp_q;
  logic                        hit_vld_q;
  logic                        rsv_q;
  logic [AW-1:0]               rd_a;
  logic [AW-1:0]               wr_a;

  assign rd_a = rd_i.addr[AW-1:0];
  assign wr_a = wr_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_a] <= wr_i.data;
    end
    if (rd_i.en) begin
      mem_rd_q   <= mem[rd_a];
      byp_data_q <= wr_i.data;
      rsv_q      <= RSV_MASK[rd_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      byp_q     <= 1'b0;
      hit_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_a] <= 1'b1;
      end
      if (rd_i.en) begin
        byp_q     <= wr_i.en && (wr_i.addr == rd_i.addr);
        hit_vld_q <= vld_q[rd_a];
      end
    end
  end

  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (hit_vld_q) begin
      rd_data_o = mem_rd_q;
    end else begin
      rd_data_o = {{(sac_pkg::COUNT_W-1){1'b0}}, rsv_q};
    end
  end

endmodule

`default_nettype wire

>>> rtl/sac_checker.sv
// Port-level checker for the slot allocator, bound to the top level.
// Depends on sac_pkg and slot_allocator_with_refcounts_unit.
`timescale 1ns / 1ps
`default_nettype none

module sac_checker #(
  parameter int SLOTS = 32
) (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     in_valid_i,
  input wire                     in_ready_o,
  input wire sac_pkg::req_word_t in_word_i,
  input wire                     out_valid_o,
  input wire                     out_ready_i,
  input wire sac_pkg::rsp_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == sac_pkg::ST_FULL ||
                    out_word_o.status == sac_pkg::ST_RANGE)
    |-> out_word_o.granted_slot == '0 && out_word_o.ref_count == '0)
    else $error("error result carries nonzero fields");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.granted_slot != '0
    |-> out_word_o.status == sac_pkg::ST_OK && out_word_o.ref_count == '0 &&
        32'(out_word_o.granted_slot) < SLOTS)
    else $error("bad grant result");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("accepted request gave no result");

endmodule

bind slot_allocator_with_refcounts_unit sac_checker #(
  .SLOTS (SLOTS)
) u_sac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
